@@ hdl/url_form_pair_splitter_macros.svh @@
// ----------------------------------------------------------------------------
// url_form_pair_splitter_macros
// assertion shorthands shared by the form splitter rtl
// ----------------------------------------------------------------------------
`ifndef URL_FORM_PAIR_SPLITTER_MACROS_SVH
`define URL_FORM_PAIR_SPLITTER_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define UFPS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define UFPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/ufps_pkg.sv @@
// ----------------------------------------------------------------------------
// ufps_pkg
// types, character codes and helpers for the form pair splitter
// ----------------------------------------------------------------------------
`default_nettype none

package ufps_pkg;

    localparam int CNT_W         = 12;
    localparam int MAX_FIELD_LEN = 4095;
    localparam logic [CNT_W-1:0] CNT_CAP =
        CNT_W'((MAX_FIELD_LEN < 4095) ? MAX_FIELD_LEN : 4095);

    // item kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // escape progress
    localparam logic [1:0] ESC_NONE = 2'd0;
    localparam logic [1:0] ESC_HIGH = 2'd1;
    localparam logic [1:0] ESC_LOW  = 2'd2;

    // characters with a meaning in the body
    localparam logic [7:0] CHAR_AMP   = 8'h26;
    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_PCT   = 8'h25;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic             byte_valid;
        logic [7:0]       decoded_byte;
        logic             in_value;
        logic             pair_end;
        logic             pair_kept;
        logic [CNT_W-1:0] name_length;
        logic [CNT_W-1:0] value_length;
        logic             body_done;
        logic             parse_error;
    } out_item_t;

    typedef struct packed {
        logic             value_phase;
        logic [1:0]       escape_phase;
        logic [3:0]       high_nibble;
        logic [CNT_W-1:0] name_count;
        logic [CNT_W-1:0] value_count;
        logic             error_seen;
        logic             any_byte_seen;
    } parse_state_t;

    // {digit ok, nibble}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hdl/ufps_ifs.sv @@
// ----------------------------------------------------------------------------
// ufps_ifs
// valid/ready channels for body items in and decoded items out
// ----------------------------------------------------------------------------
`default_nettype none

interface ufps_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface ufps_out_if;
    logic        valid;
    logic        ready;
    logic        byte_valid;
    logic [7:0]  decoded_byte;
    logic        in_value;
    logic        pair_end;
    logic        pair_kept;
    logic [11:0] name_length;
    logic [11:0] value_length;
    logic        body_done;
    logic        parse_error;

    modport source (
        output valid, output byte_valid, output decoded_byte, output in_value,
        output pair_end, output pair_kept, output name_length,
        output value_length, output body_done, output parse_error,
        input ready
    );
    modport sink (
        input valid, input byte_valid, input decoded_byte, input in_value,
        input pair_end, input pair_kept, input name_length,
        input value_length, input body_done, input parse_error,
        output ready
    );
endinterface

`default_nettype wire

@@ hdl/ufps_decoder.sv @@
// ----------------------------------------------------------------------------
// ufps_decoder
// one-item decode step: parse state and item in, next state and result out
// ----------------------------------------------------------------------------
`default_nettype none

module ufps_decoder
    import ufps_pkg::*;
(
    input  parse_state_t state,
    input  in_item_t     item,
    output parse_state_t state_next,
    output out_item_t    result
);

    logic [4:0]       hex;
    logic             pair_open;
    logic             cnt_inc;
    logic [7:0]       plain_byte;

    assign hex        = hex_decode(item.data_byte);
    assign plain_byte = (item.data_byte == CHAR_PLUS) ? CHAR_SPACE : item.data_byte;
    assign pair_open  = (state.name_count != '0) || (state.value_count != '0) ||
                        state.value_phase || (state.escape_phase != ESC_NONE);

    always_comb
    begin
        state_next = state;
        result     = '0;
        cnt_inc    = 1'b0;

        if (item.kind == KIND_END)
        begin
            result.body_done   = 1'b1;
            result.parse_error = state.error_seen | ~state.any_byte_seen |
                                 (state.escape_phase != ESC_NONE);
            if (state.any_byte_seen && pair_open)
            begin
                result.pair_end     = 1'b1;
                result.pair_kept    = (state.name_count != '0);
                result.name_length  = state.name_count;
                result.value_length = state.value_count;
            end
            state_next = '0;
        end
        else
        begin
            state_next.any_byte_seen = 1'b1;
            unique case (state.escape_phase)
                ESC_HIGH:
                begin
                    if (!hex[4])
                    begin
                        state_next.error_seen   = 1'b1;
                        state_next.escape_phase = ESC_NONE;
                    end
                    else
                    begin
                        state_next.high_nibble  = hex[3:0];
                        state_next.escape_phase = ESC_LOW;
                    end
                end
                ESC_LOW:
                begin
                    state_next.escape_phase = ESC_NONE;
                    if (!hex[4])
                    begin
                        state_next.error_seen = 1'b1;
                    end
                    else
                    begin
                        result.byte_valid   = 1'b1;
                        result.decoded_byte = {state.high_nibble, hex[3:0]};
                        result.in_value     = state.value_phase;
                        cnt_inc             = 1'b1;
                    end
                end
                default:
                begin
                    priority if (item.data_byte == CHAR_AMP)
                    begin
                        result.pair_end        = 1'b1;
                        result.pair_kept       = (state.name_count != '0);
                        result.name_length     = state.name_count;
                        result.value_length    = state.value_count;
                        state_next.name_count  = '0;
                        state_next.value_count = '0;
                        state_next.value_phase = 1'b0;
                    end
                    else if (item.data_byte == CHAR_EQ && !state.value_phase)
                    begin
                        state_next.value_phase = 1'b1;
                    end
                    else if (item.data_byte == CHAR_PCT)
                    begin
                        state_next.escape_phase = ESC_HIGH;
                    end
                    else
                    begin
                        result.byte_valid   = 1'b1;
                        result.decoded_byte = plain_byte;
                        result.in_value     = state.value_phase;
                        cnt_inc             = 1'b1;
                    end
                end
            endcase

            // saturating length count of the current field
            if (cnt_inc)
            begin
                if (state.value_phase)
                begin
                    if (state.value_count < CNT_CAP)
                    begin
                        state_next.value_count = state.value_count + 1'b1;
                    end
                end
                else if (state.name_count < CNT_CAP)
                begin
                    state_next.name_count = state.name_count + 1'b1;
                end
            end
            result.parse_error = state_next.error_seen;
        end
    end

endmodule

`default_nettype wire

@@ hdl/url_form_pair_splitter.sv @@
// ----------------------------------------------------------------------------
// url_form_pair_splitter
// urlencoded form body decoder: splits name/value pairs, decodes '+' and %XX
//
//   channel   role   payload
//   in_ch     sink   kind, data_byte (one body byte or end of body)
//   out_ch    source decoded byte, pair close with lengths, body done, error
//
// one item accepted per cycle while out_ch takes results; each item gives exactly one result item
// an item passes through the input register, then is decoded into the result register
// parse state updates as an item moves from input register to result register
// stalls on out_ch back up through both registers; ready only drops when both full
// reset clears valid flags and parse state; no clearing pass needed
// ----------------------------------------------------------------------------
`default_nettype none

`include "url_form_pair_splitter_macros.svh"

module url_form_pair_splitter
    import ufps_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    ufps_in_if.sink    in_ch,
    ufps_out_if.source out_ch
);

    // input register
    logic         s1_valid_reg;
    logic         s1_valid_next;
    in_item_t     s1_item_reg;

    // result register
    logic         out_valid_reg;
    logic         out_valid_next;
    out_item_t    out_item_reg;

    // parse state of the current body
    parse_state_t state_reg;
    parse_state_t state_next;
    out_item_t    result;

    logic         in_fire;
    logic         advance;

    // decode step moves an item on whenever the result slot is free or draining
    assign advance     = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || advance;
    assign in_fire     = in_ch.valid && in_ch.ready;

    ufps_decoder u_decoder (
        .state      (state_reg),
        .item       (s1_item_reg),
        .state_next (state_next),
        .result     (result)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg.kind      <= in_ch.kind;
            s1_item_reg.data_byte <= in_ch.data_byte;
        end
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.byte_valid   = out_item_reg.byte_valid;
    assign out_ch.decoded_byte = out_item_reg.decoded_byte;
    assign out_ch.in_value     = out_item_reg.in_value;
    assign out_ch.pair_end     = out_item_reg.pair_end;
    assign out_ch.pair_kept    = out_item_reg.pair_kept;
    assign out_ch.name_length  = out_item_reg.name_length;
    assign out_ch.value_length = out_item_reg.value_length;
    assign out_ch.body_done    = out_item_reg.body_done;
    assign out_ch.parse_error  = out_item_reg.parse_error;

    // a decoded byte never comes with a pair close or end of body
    `UFPS_ASSERT_SAME(a_byte_alone, out_valid_reg && out_item_reg.byte_valid,
        !out_item_reg.pair_end && !out_item_reg.body_done, "byte with pair close")
    // a kept pair has a nonempty name
    `UFPS_ASSERT_SAME(a_kept_named, out_valid_reg && out_item_reg.pair_kept,
        out_item_reg.pair_end && (out_item_reg.name_length != '0), "kept pair unnamed")
    // end of body leaves the parser in its reset state
    `UFPS_ASSERT_NEXT(a_body_clear, advance && (s1_item_reg.kind == KIND_END),
        state_reg == '0, "state not cleared after end of body")
    // the result register only loads when its slot is free or being taken
    `UFPS_ASSERT_SAME(a_no_overwrite, advance && out_valid_reg,
        out_ch.ready, "result overwritten while stalled")

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the urlencoded form pair splitter: a directed table
// of body items, then random bodies under several idling mixes, scored against
// hand-typed expectations or a predictor
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ufps_pkg::*;

    // cycles with no item moved on either channel before the run is abandoned
    localparam int WATCHDOG_LIMIT = 2000;
    // quiet cycles after the last result
    localparam int DRAIN_CYCLES   = 10;
    // random items per idling phase
    localparam int PHASE_ITEMS    = 360;
    localparam int NUM_PHASES     = 4;

    typedef struct {
        in_item_t  item;
        bit        fixed;
        out_item_t want;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n;

    ufps_in_if  in_ch ();
    ufps_out_if out_ch ();

    url_form_pair_splitter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // idling mix of the current phase, in percent per cycle
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    // results still owed by the block, oldest first
    out_item_t   owed_results[$];
    int unsigned fail_count;
    int unsigned quiet_cycles;
    int unsigned phase_items;

    // raw bytes of the next body to send
    logic [7:0]  body_bytes[$];

    directed_row_t directed_rows[$];

    // predictor copy of the parse state
    logic             in_value_part;
    logic [1:0]       esc_step;
    logic [3:0]       upper_nibble;
    logic [CNT_W-1:0] name_len_cnt;
    logic [CNT_W-1:0] value_len_cnt;
    logic             err_flag;
    logic             body_started;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // value of a hex digit in either case, -1 for anything else
    function automatic int nibble_of(input logic [7:0] c);
        int v;
        v = -1;
        case (c) inside
            ["0":"9"]: v = int'(c) - int'("0");
            ["A":"F"]: v = int'(c) - int'("A") + 10;
            ["a":"f"]: v = int'(c) - int'("a") + 10;
            default:   v = -1;
        endcase
        return v;
    endfunction

    // one more decoded byte in the current half of the pair, saturating
    function automatic void count_decoded();
        if (in_value_part)
        begin
            if (value_len_cnt < CNT_CAP)
                value_len_cnt = value_len_cnt + 1'b1;
        end
        else
        begin
            if (name_len_cnt < CNT_CAP)
                name_len_cnt = name_len_cnt + 1'b1;
        end
    endfunction

    function automatic void clear_parse();
        in_value_part = 1'b0;
        esc_step      = ESC_NONE;
        upper_nibble  = '0;
        name_len_cnt  = '0;
        value_len_cnt = '0;
        err_flag      = 1'b0;
        body_started  = 1'b0;
    endfunction

    function automatic out_item_t predict_decoded(input in_item_t it);
        out_item_t r;
        int        nib;
        logic      open_pair;
        r = '0;
        if (it.kind == KIND_BYTE)
        begin
            body_started = 1'b1;
            nib = nibble_of(it.data_byte);
            if (esc_step == ESC_HIGH)
            begin
                // bad first digit drops the byte and abandons the escape
                if (nib < 0)
                begin
                    err_flag = 1'b1;
                    esc_step = ESC_NONE;
                end
                else
                begin
                    upper_nibble = nib[3:0];
                    esc_step     = ESC_LOW;
                end
            end
            else if (esc_step == ESC_LOW)
            begin
                esc_step = ESC_NONE;
                if (nib < 0)
                begin
                    err_flag = 1'b1;
                end
                else
                begin
                    r.byte_valid   = 1'b1;
                    r.decoded_byte = {upper_nibble, nib[3:0]};
                    r.in_value     = in_value_part;
                    count_decoded();
                end
            end
            else if (it.data_byte == CHAR_AMP)
            begin
                r.pair_end     = 1'b1;
                r.pair_kept    = (name_len_cnt != '0);
                r.name_length  = name_len_cnt;
                r.value_length = value_len_cnt;
                name_len_cnt   = '0;
                value_len_cnt  = '0;
                in_value_part  = 1'b0;
            end
            else if (it.data_byte == CHAR_EQ && !in_value_part)
            begin
                in_value_part = 1'b1;
            end
            else if (it.data_byte == CHAR_PCT)
            begin
                esc_step = ESC_HIGH;
            end
            else
            begin
                r.byte_valid   = 1'b1;
                r.decoded_byte = (it.data_byte == CHAR_PLUS) ? CHAR_SPACE : it.data_byte;
                r.in_value     = in_value_part;
                count_decoded();
            end
            r.parse_error = err_flag;
        end
        else
        begin
            open_pair = (name_len_cnt != '0) || (value_len_cnt != '0) ||
                        in_value_part || (esc_step != ESC_NONE);
            r.body_done   = 1'b1;
            // empty body and an escape cut off by the end both count as errors
            r.parse_error = err_flag || !body_started || (esc_step != ESC_NONE);
            if (body_started && open_pair)
            begin
                r.pair_end     = 1'b1;
                r.pair_kept    = (name_len_cnt != '0);
                r.name_length  = name_len_cnt;
                r.value_length = value_len_cnt;
            end
            clear_parse();
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // directed table helpers
    // ------------------------------------------------------------------------

    // expected item with no kept pair and zero lengths, for rows typed in by hand
    function automatic out_item_t outcome(input logic bv, input logic [7:0] db,
                                          input logic iv, input logic pe,
                                          input logic bd, input logic err);
        return {bv, db, iv, pe, 1'b0, 12'd0, 12'd0, bd, err};
    endfunction

    function automatic directed_row_t row(input logic k, input logic [7:0] b,
                                          input bit fixed, input out_item_t want);
        directed_row_t r;
        r.item.kind      = k;
        r.item.data_byte = b;
        r.fixed          = fixed;
        r.want           = want;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------------

    // offer one item, wait for the handshake and record what it should give;
    // valid stays high after acceptance so back-to-back items need no gap
    task automatic send_item(input in_item_t it, input bit fixed, input out_item_t want);
        out_item_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= it.kind;
        in_ch.data_byte <= it.data_byte;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        // the predictor always runs so its state tracks the block
        predicted = predict_decoded(it);
        owed_results.push_back(fixed ? want : predicted);
        phase_items++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        in_item_t it;
        it.kind      = KIND_BYTE;
        it.data_byte = b;
        send_item(it, 1'b0, '0);
    endtask

    // body bytes first, then the end item with a junk data byte
    task automatic send_body();
        in_item_t it;
        foreach (body_bytes[i])
            send_byte(body_bytes[i]);
        it.kind      = KIND_END;
        it.data_byte = 8'($urandom_range(255));
        send_item(it, 1'b0, '0);
        body_bytes.delete();
    endtask

    // sender holds off until the block owes nothing
    task automatic settle_pipeline();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (owed_results.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // random body generation
    // ------------------------------------------------------------------------

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10)
            return 8'("0") + 8'(n);
        return (upper ? 8'("A") : 8'("a")) + 8'(n - 4'd10);
    endfunction

    // one name or value character, mostly well formed
    task automatic push_text_char();
        int unsigned pick;
        logic [7:0]  v;
        pick = $urandom_range(99);
        v    = 8'($urandom_range(255));
        if (pick < 40)
            body_bytes.push_back(8'($urandom_range(8'h61, 8'h7a)));
        else if (pick < 50)
            body_bytes.push_back(8'($urandom_range(8'h30, 8'h39)));
        else if (pick < 60)
            body_bytes.push_back(CHAR_PLUS);
        else if (pick < 80)
        begin
            // good escape of any byte value, random digit case
            body_bytes.push_back(CHAR_PCT);
            body_bytes.push_back(hex_char(v[7:4], 1'($urandom_range(1))));
            body_bytes.push_back(hex_char(v[3:0], 1'($urandom_range(1))));
        end
        else if (pick < 85)
            body_bytes.push_back(CHAR_EQ);
        else if (pick < 90)
        begin
            // broken escape, bad digit in first or second place
            body_bytes.push_back(CHAR_PCT);
            if ($urandom_range(1))
                body_bytes.push_back(hex_char(v[3:0], 1'($urandom_range(1))));
            body_bytes.push_back(8'($urandom_range(8'h67, 8'h7a)));
        end
        else
            body_bytes.push_back(v);
    endtask

    task automatic build_body();
        int unsigned mode;
        int unsigned pairs;
        int unsigned len;
        int unsigned tail;
        mode = $urandom_range(99);
        if (mode < 8)
        begin
            // noise: raw bytes of any value
            len = $urandom_range(12);
            repeat (len)
                body_bytes.push_back(8'($urandom_range(255)));
        end
        else if (mode >= 11)
        begin
            pairs = $urandom_range(1, 4);
            for (int p = 0; p < pairs; p++)
            begin
                if (p > 0)
                    body_bytes.push_back(CHAR_AMP);
                len = $urandom_range(5);
                repeat (len)
                    push_text_char();
                if ($urandom_range(3) != 0)
                    body_bytes.push_back(CHAR_EQ);
                len = $urandom_range(6);
                repeat (len)
                    push_text_char();
            end
            // trailing separator, or an escape cut short by the end
            tail = $urandom_range(19);
            if (tail == 0)
                body_bytes.push_back(CHAR_AMP);
            else if (tail == 1)
                body_bytes.push_back(CHAR_PCT);
            else if (tail == 2)
            begin
                body_bytes.push_back(CHAR_PCT);
                body_bytes.push_back(hex_char(4'($urandom_range(15)),
                                              1'($urandom_range(1))));
            end
        end
        // otherwise an empty body: just the end item
    endtask

    // ------------------------------------------------------------------------
    // receiver side
    // ------------------------------------------------------------------------

    initial
        out_ch.ready = 1'b0;

    always @(posedge clk)
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic check_field(input string fname, input logic [11:0] want,
                               input logic [11:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", fname, want, got);
            fail_count++;
        end
    endtask

    // scoreboard and watchdog, sampled at the edge where the handshake lands
    always @(posedge clk)
    begin
        out_item_t want;
        logic      in_fire;
        logic      out_fire;
        if (rst_n)
        begin
            in_fire  = in_ch.valid && in_ch.ready;
            out_fire = out_ch.valid && out_ch.ready;
            if (out_fire)
            begin
                if (owed_results.size() == 0)
                begin
                    $error("result item with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    check_field("byte_valid",   12'(want.byte_valid),
                                12'(out_ch.byte_valid));
                    check_field("decoded_byte", 12'(want.decoded_byte),
                                12'(out_ch.decoded_byte));
                    check_field("in_value",     12'(want.in_value),
                                12'(out_ch.in_value));
                    check_field("pair_end",     12'(want.pair_end),
                                12'(out_ch.pair_end));
                    check_field("pair_kept",    12'(want.pair_kept),
                                12'(out_ch.pair_kept));
                    check_field("name_length",  want.name_length,  out_ch.name_length);
                    check_field("value_length", want.value_length, out_ch.value_length);
                    check_field("body_done",    12'(want.body_done),
                                12'(out_ch.body_done));
                    check_field("parse_error",  12'(want.parse_error),
                                12'(out_ch.parse_error));
                end
            end
            if (in_fire || out_fire)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        int unsigned send_mix[NUM_PHASES];
        int unsigned recv_mix[NUM_PHASES];
        send_mix = '{0, 49, 0, 26};
        recv_mix = '{0, 0, 49, 26};

        in_ch.valid     = 1'b0;
        in_ch.kind      = KIND_BYTE;
        in_ch.data_byte = '0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        fail_count      = 0;
        quiet_cycles    = 0;
        phase_items     = 0;
        clear_parse();

        rst_n = 1'b0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty body straight after reset
        directed_rows.push_back(row(KIND_END, 8'h00, 1, outcome(0, 8'h00, 0, 0, 1, 1)));
        // byte extremes, plus to space, first equals opens the value
        directed_rows.push_back(row(KIND_BYTE, 8'h00, 1, outcome(1, 8'h00, 0, 0, 0, 0)));
        directed_rows.push_back(row(KIND_BYTE, 8'hFF, 1, outcome(1, 8'hFF, 0, 0, 0, 0)));
        directed_rows.push_back(row(KIND_BYTE, CHAR_PLUS, 1, outcome(1, CHAR_SPACE, 0, 0, 0, 0)));
        directed_rows.push_back(row(KIND_BYTE, CHAR_EQ, 1, outcome(0, 8'h00, 0, 0, 0, 0)));
        // a later equals inside the value is literal
        directed_rows.push_back(row(KIND_BYTE, CHAR_EQ, 1, outcome(1, CHAR_EQ, 1, 0, 0, 0)));
        // escapes, mixed digit case
        directed_rows.push_back(row(KIND_BYTE, CHAR_PCT, 1, outcome(0, 8'h00, 0, 0, 0, 0)));
        directed_rows.push_back(row(KIND_BYTE, "A", 1, outcome(0, 8'h00, 0, 0, 0, 0)));
        directed_rows.push_back(row(KIND_BYTE, "f", 0, '0));
        directed_rows.push_back(row(KIND_BYTE, CHAR_PCT, 0, '0));
        directed_rows.push_back(row(KIND_BYTE, "9", 0, '0));
        directed_rows.push_back(row(KIND_BYTE, "0", 0, '0));
        // close the pair, then an empty one
        directed_rows.push_back(row(KIND_BYTE, CHAR_AMP, 0, '0));
        directed_rows.push_back(row(KIND_BYTE, CHAR_AMP, 1, outcome(0, 8'h00, 0, 1, 0, 0)));
        // bad high digit, then bad low digit
        directed_rows.push_back(row(KIND_BYTE, CHAR_PCT, 1, outcome(0, 8'h00, 0, 0, 0, 0)));
        directed_rows.push_back(row(KIND_BYTE, "g", 1, outcome(0, 8'h00, 0, 0, 0, 1)));
        directed_rows.push_back(row(KIND_BYTE, CHAR_PCT, 0, '0));
        directed_rows.push_back(row(KIND_BYTE, "4", 0, '0));
        directed_rows.push_back(row(KIND_BYTE, "z", 0, '0));
        // empty name with a value, body ends inside an escape
        directed_rows.push_back(row(KIND_BYTE, CHAR_EQ, 0, '0));
        directed_rows.push_back(row(KIND_BYTE, "x", 0, '0));
        directed_rows.push_back(row(KIND_BYTE, CHAR_PCT, 0, '0));
        directed_rows.push_back(row(KIND_END, 8'hFF, 0, '0));
        // body that is only a separator closes no extra pair
        directed_rows.push_back(row(KIND_BYTE, CHAR_AMP, 0, '0));
        directed_rows.push_back(row(KIND_END, 8'h00, 0, '0));

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].want);
        settle_pipeline();

        // random bodies under each idling mix, fully drained in between
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            send_idle_pct  = send_mix[ph];
            recv_stall_pct = recv_mix[ph];
            phase_items    = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                build_body();
                send_body();
            end
            settle_pipeline();
        end

        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
